FILE: rtl/sprite_quad_vertex_batcher_top_macros.svh
// Assertion macros shared by the vertex batcher checks
`ifndef SPRITE_QUAD_VERTEX_BATCHER_TOP_MACROS_SVH
`define SPRITE_QUAD_VERTEX_BATCHER_TOP_MACROS_SVH

// Same-cycle implication, quiet during reset
`define SQVB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, quiet during reset
`define SQVB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: rtl/sqvb_pkg.sv
// Shared types, constants and the sine table builder for the vertex batcher
package sqvb_pkg;

    localparam int unsigned SINE_DEPTH = 256;
    localparam int unsigned SINE_BITS  = 8;
    localparam int unsigned SLOT_W     = 11;
    localparam logic [14:0] Q14_ONE    = 15'd16384;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef logic [14:0] t_sine_rom [SINE_DEPTH];

    // One sprite after classification, as held in the queue
    typedef struct packed {
        logic                fresh;
        logic [SLOT_W-1:0]   slot;
        logic [15:0]         batch_texture;
        logic [12:0]         tex_width;
        logic [12:0]         tex_height;
        logic signed [23:0]  pos_x;
        logic signed [23:0]  pos_y;
        logic signed [23:0]  origin_x;
        logic signed [23:0]  origin_y;
        logic signed [16:0]  sin_q;
        logic signed [16:0]  cos_q;
        logic [15:0]         scale;
        logic [31:0]         color;
    } t_sprite_job;

    // Per-vertex side data carried down the arithmetic pipe
    typedef struct packed {
        logic [31:0]         color;
        logic                tex_u;
        logic                tex_v;
        logic [1:0]          corner;
        logic                batch_start;
        logic [SLOT_W-1:0]   slot;
        logic [15:0]         batch_texture;
        logic                last;
        logic signed [23:0]  pos_x;
        logic signed [23:0]  pos_y;
        logic [15:0]         scale;
    } t_vtx_meta;

    // Quarter-wave sine in Q1.14 from a truncated Taylor series in Q30
    function automatic logic [14:0] sine_q14(input int unsigned i);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] plus;
        logic [63:0] minus;
        logic [63:0] sum;
        logic [63:0] r;
        x     = (PI_HALF_Q30 * 64'(i)) / SINE_DEPTH;
        term  = x;
        plus  = x;
        minus = 64'd0;
        for (int k = 1; k <= 7; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            unique case (k)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                default: term = term / 210;
            endcase
            if (k[0]) minus = minus + term;
            else      plus  = plus + term;
        end
        sum = (plus > minus) ? plus - minus : 64'd0;
        r   = (sum + 64'd32768) >> 16;
        if (r > 64'(Q14_ONE)) r = 64'(Q14_ONE);
        return r[14:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i < SINE_DEPTH; i++) rom[i] = sine_q14(i);
        return rom;
    endfunction

endpackage

FILE: rtl/sqvb_if.sv
// Valid/ready channel interfaces for sprites in and vertices out
interface sqvb_sprite_if;
    logic               valid;
    logic               ready;
    logic               frame_start;
    logic [15:0]        texture_id;
    logic [12:0]        tex_width;
    logic [12:0]        tex_height;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [15:0]        angle;
    logic [15:0]        scale;
    logic [31:0]        color;

    modport source (output valid, frame_start, texture_id, tex_width, tex_height, pos_x,
                    pos_y, origin_x, origin_y, angle, scale, color, input ready);
    modport sink   (input valid, frame_start, texture_id, tex_width, tex_height, pos_x,
                    pos_y, origin_x, origin_y, angle, scale, color, output ready);
endinterface

interface sqvb_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [31:0]        vertex_color;
    logic               tex_u;
    logic               tex_v;
    logic [1:0]         corner;
    logic               batch_start;
    logic [10:0]        slot;
    logic [15:0]        batch_texture;
    logic               last;

    modport source (output valid, vertex_x, vertex_y, vertex_color, tex_u, tex_v, corner,
                    batch_start, slot, batch_texture, last, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_color, tex_u, tex_v, corner,
                    batch_start, slot, batch_texture, last, output ready);
endinterface

FILE: rtl/sqvb_queue.sv
// Two-entry queue between the sprite classifier and the vertex engine
module sqvb_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sqvb_pkg::t_sprite_job i_job,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output sqvb_pkg::t_sprite_job o_job
);
    sqvb_pkg::t_sprite_job r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    // Store the word at the write pointer
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            if (i_push && !i_pop)      r_count <= r_count + 2'd1;
            else if (!i_push && i_pop) r_count <= r_count - 2'd1;
        end
    end
endmodule

FILE: rtl/sqvb_front.sv
// Sprite intake: batch bookkeeping and sine/cosine lookup
module sqvb_front #(
    parameter int unsigned MAX_BATCH_SPRITES = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sqvb_sprite_if.sink           i_sprite,
    input  logic                  i_full,
    output logic                  o_push,
    output sqvb_pkg::t_sprite_job o_job
);
    localparam int unsigned CNT_W = $clog2(MAX_BATCH_SPRITES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BATCH_SPRITES);
    localparam sqvb_pkg::t_sine_rom SINE_ROM = sqvb_pkg::build_sine_rom();

    logic [15:0]      r_tex;
    logic [CNT_W-1:0] r_count;
    logic             r_open;

    logic                           accept;
    logic                           fresh;
    logic [1:0]                     quad;
    logic [sqvb_pkg::SINE_BITS-1:0] idx;
    logic [sqvb_pkg::SINE_BITS-1:0] idx_m;
    logic signed [16:0]             qa;
    logic signed [16:0]             qb;
    logic signed [16:0]             sin_q;
    logic signed [16:0]             cos_q;

    assign i_sprite.ready = !i_full;
    assign accept = i_sprite.valid && !i_full;
    assign o_push = accept;

    // Classify: open a new batch when needed
    assign fresh = i_sprite.frame_start || !r_open || (i_sprite.texture_id != r_tex)
                   || (r_count >= CNT_MAX);

    // Look up the quarter wave at the angle and at its mirror
    assign quad  = i_sprite.angle[15:14];
    assign idx   = i_sprite.angle[13 -: sqvb_pkg::SINE_BITS];
    assign idx_m = ~idx + 1'b1;
    assign qa    = $signed({2'b00, SINE_ROM[idx]});
    assign qb    = (idx == '0) ? $signed({2'b00, sqvb_pkg::Q14_ONE})
                               : $signed({2'b00, SINE_ROM[idx_m]});

    // Fold the quadrant into signs
    always_comb begin
        unique case (quad)
            2'd0: begin sin_q = qa;  cos_q = qb;  end
            2'd1: begin sin_q = qb;  cos_q = -qa; end
            2'd2: begin sin_q = -qa; cos_q = -qb; end
            default: begin sin_q = -qb; cos_q = qa; end
        endcase
    end

    // Assemble the queue word
    always_comb begin
        o_job.fresh         = fresh;
        o_job.slot          = fresh ? '0 : sqvb_pkg::SLOT_W'(r_count);
        o_job.batch_texture = fresh ? i_sprite.texture_id : r_tex;
        o_job.tex_width     = i_sprite.tex_width;
        o_job.tex_height    = i_sprite.tex_height;
        o_job.pos_x         = i_sprite.pos_x;
        o_job.pos_y         = i_sprite.pos_y;
        o_job.origin_x      = i_sprite.origin_x;
        o_job.origin_y      = i_sprite.origin_y;
        o_job.sin_q         = sin_q;
        o_job.cos_q         = cos_q;
        o_job.scale         = i_sprite.scale;
        o_job.color         = i_sprite.color;
    end

    // Update batch state on each accepted sprite
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex   <= 16'd0;
            r_count <= '0;
            r_open  <= 1'b0;
        end else if (accept) begin
            r_open <= 1'b1;
            if (fresh) begin
                r_tex   <= i_sprite.texture_id;
                r_count <= CNT_W'(1);
            end else begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end
endmodule

FILE: rtl/sqvb_back.sv
// Vertex engine: one corner per cycle, while the output is not stalled, through a four-stage transform pipe
module sqvb_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  sqvb_pkg::t_sprite_job i_job,
    output logic                  o_pop,
    sqvb_vertex_if.source         o_vertex
);
    logic       en;
    logic [1:0] r_corner;
    logic       cu;
    logic       cv;
    logic signed [24:0] lx;
    logic signed [24:0] ly;
    sqvb_pkg::t_vtx_meta meta0;

    logic r1_v, r2_v, r3_v, r_ov;
    sqvb_pkg::t_vtx_meta r1_m, r2_m, r3_m;
    logic signed [41:0] r1_lxc, r1_lys, r1_lxs, r1_lyc;
    logic signed [42:0] r2_rx, r2_ry;
    logic signed [38:0] r3_xh, r3_xl, r3_yh, r3_yl;
    logic signed [16:0] sc17;
    logic signed [31:0] n_x, n_y;

    logic signed [31:0] r_x, r_y;
    sqvb_pkg::t_vtx_meta r_m;

    // Saturate the scaled offset plus position to 32 bits
    function automatic logic signed [31:0] finish(input logic signed [38:0] hi,
                                                  input logic signed [38:0] lo,
                                                  input logic signed [23:0] pos);
        logic signed [60:0] full;
        logic signed [60:0] t;
        logic signed [39:0] v;
        full = (61'(hi) <<< 21) + 61'(lo);
        t    = full + (61'sd1 <<< 21);
        v    = 40'(pos) + 40'($signed(t[60:22]));
        if (v > 40'sd2147483647)       return 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    assign en    = !r_ov || o_vertex.ready;
    assign o_pop = en && i_valid && (r_corner == 2'd3);

    // Local corner minus origin
    assign cu = r_corner[0] ^ r_corner[1];
    assign cv = r_corner[1];
    assign lx = $signed({4'b0, (cu ? i_job.tex_width  : 13'd0), 8'd0}) - 25'(i_job.origin_x);
    assign ly = $signed({4'b0, (cv ? i_job.tex_height : 13'd0), 8'd0}) - 25'(i_job.origin_y);

    always_comb begin
        meta0.color         = i_job.color;
        meta0.tex_u         = cu;
        meta0.tex_v         = cv;
        meta0.corner        = r_corner;
        meta0.batch_start   = i_job.fresh && (r_corner == 2'd0);
        meta0.slot          = i_job.slot;
        meta0.batch_texture = i_job.batch_texture;
        meta0.last          = (r_corner == 2'd3);
        meta0.pos_x         = i_job.pos_x;
        meta0.pos_y         = i_job.pos_y;
        meta0.scale         = i_job.scale;
    end

    assign sc17 = $signed({1'b0, r2_m.scale});
    assign n_x  = finish(r3_xh, r3_xl, r3_m.pos_x);
    assign n_y  = finish(r3_yh, r3_yl, r3_m.pos_y);

    // Step the corner counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_corner <= 2'd0;
        else if (en && i_valid) r_corner <= r_corner + 2'd1;
    end

    // Advance stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_ov <= r3_v;
        end
    end

    // Rotate, then scale in split partial products, then round and saturate
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_m   <= meta0;
            r1_lxc <= 42'(lx * i_job.cos_q);
            r1_lys <= 42'(ly * i_job.sin_q);
            r1_lxs <= 42'(lx * i_job.sin_q);
            r1_lyc <= 42'(ly * i_job.cos_q);
            r2_m   <= r1_m;
            r2_rx  <= 43'(r1_lxc) - 43'(r1_lys);
            r2_ry  <= 43'(r1_lxs) + 43'(r1_lyc);
            r3_m   <= r2_m;
            r3_xh  <= 39'($signed(r2_rx[42:21]) * sc17);
            r3_xl  <= 39'($signed({1'b0, r2_rx[20:0]}) * sc17);
            r3_yh  <= 39'($signed(r2_ry[42:21]) * sc17);
            r3_yl  <= 39'($signed({1'b0, r2_ry[20:0]}) * sc17);
            r_m    <= r3_m;
            r_x    <= n_x;
            r_y    <= n_y;
        end
    end

    assign o_vertex.valid         = r_ov;
    assign o_vertex.vertex_x      = r_x;
    assign o_vertex.vertex_y      = r_y;
    assign o_vertex.vertex_color  = r_m.color;
    assign o_vertex.tex_u         = r_m.tex_u;
    assign o_vertex.tex_v         = r_m.tex_v;
    assign o_vertex.corner        = r_m.corner;
    assign o_vertex.batch_start   = r_m.batch_start;
    assign o_vertex.slot          = r_m.slot;
    assign o_vertex.batch_texture = r_m.batch_texture;
    assign o_vertex.last          = r_m.last;
endmodule

FILE: rtl/sprite_quad_vertex_batcher_top.sv
// Sprite quad vertex batcher: sprites in, four transformed corner vertices out.
// i_sprite carries one sprite per word (valid/ready); o_vertex carries one
// corner vertex per word, corners 0..3 clockwise from top-left, last on corner 3.
// The front end classifies each sprite into a batch (frame start, texture change
// or a full batch opens a new one) and looks up sine and cosine; the word then
// waits in a two-entry queue. The vertex engine issues one corner per cycle while
// the output is not stalled, into a four-stage rotate/scale pipe ending in the
// output register. The engine pops a sprite when its corner 3 issues and can
// start the next sprite's corners straight after. An accepted sprite is written
// into the queue, then each corner passes r1, r2, r3 and the output register.
// A stalled receiver freezes the whole pipe; the queue fills and then i_sprite
// ready drops, so nothing is lost. Synchronous active-low reset clears batch
// state (no open batch), the queue and all pipe valid bits.
module sprite_quad_vertex_batcher_top #(
    parameter int unsigned MAX_BATCH_SPRITES = 2048
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sqvb_sprite_if.sink     i_sprite,
    sqvb_vertex_if.source   o_vertex
);
    logic                  push;
    logic                  full;
    logic                  pop;
    logic                  q_valid;
    sqvb_pkg::t_sprite_job front_job;
    sqvb_pkg::t_sprite_job q_job;

    sqvb_front #(.MAX_BATCH_SPRITES(MAX_BATCH_SPRITES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sprite (i_sprite),
        .i_full   (full),
        .o_push   (push),
        .o_job    (front_job)
    );

    sqvb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    sqvb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (q_job),
        .o_pop    (pop),
        .o_vertex (o_vertex)
    );
endmodule

FILE: rtl/sqvb_checker.sv
// Port-level checks on the vertex output of the batcher
`include "sprite_quad_vertex_batcher_top_macros.svh"

module sqvb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] vertex_x,
    input logic               tex_u,
    input logic               tex_v,
    input logic [1:0]         corner,
    input logic               batch_start,
    input logic [10:0]        slot,
    input logic               last
);
    `SQVB_ASSERT_IMPLY(a_last_on_corner3, i_clk, i_rst_n, out_valid, last == (corner == 2'd3))
    `SQVB_ASSERT_IMPLY(a_start_first_slot, i_clk, i_rst_n, out_valid && batch_start,
        (corner == 2'd0) && (slot == 11'd0))
    `SQVB_ASSERT_IMPLY(a_tex_coords, i_clk, i_rst_n, out_valid,
        (tex_u == (corner == 2'd1 || corner == 2'd2)) && (tex_v == corner[1]))
    `SQVB_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, out_valid && !out_ready,
        out_valid && $stable(vertex_x) && $stable(corner))
endmodule

bind sprite_quad_vertex_batcher_top sqvb_checker u_sqvb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .out_valid   (o_vertex.valid),
    .out_ready   (o_vertex.ready),
    .vertex_x    (o_vertex.vertex_x),
    .tex_u       (o_vertex.tex_u),
    .tex_v       (o_vertex.tex_v),
    .corner      (o_vertex.corner),
    .batch_start (o_vertex.batch_start),
    .slot        (o_vertex.slot),
    .last        (o_vertex.last)
);
